// ===== rtl/mkdb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-key debouncer package
// Shared types and constants: flag bits, timer actions, commands, register
// indexes and the per-key update record.
// ----------------------------------------------------------------------------
package mkdb_pkg;

  // Flag word bit positions.
  localparam int FL_UNSTABLE  = 0;
  localparam int FL_PRESSED   = 1;
  localparam int FL_NOTPRESSED = 2;
  localparam int FL_WAIT      = 3;
  localparam int FL_POLL      = 4;

  localparam logic [4:0] FLAGS_UNKNOWN   = 5'b00110;
  localparam logic [4:0] FLAGS_PRESSED   = 5'b00010;
  localparam logic [4:0] FLAGS_NOTPRESSED = 5'b00100;
  localparam logic [4:0] FLAGS_UNSTABLE  = 5'b00001;
  localparam logic [4:0] FLAGS_WAIT      = 5'b01000;
  localparam logic [4:0] FLAGS_POLL      = 5'b10000;

  // Next timer action codes.
  localparam logic [1:0] TMR_STOP     = 2'd0;
  localparam logic [1:0] TMR_DEBOUNCE = 2'd1;
  localparam logic [1:0] TMR_POLL     = 2'd2;
  localparam logic [1:0] TMR_KEEP     = 2'd3;

  // Input commands and result kinds.
  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_EDGE    = 1'b1;
  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ACTIVE_HIGH = 2'd0;
  localparam logic [1:0] CFG_EDGE_MODE   = 2'd1;
  localparam logic [1:0] CFG_DEBOUNCE_ON = 2'd2;
  localparam logic [1:0] CFG_KEY_COUNT   = 2'd3;

  // Outcome of scanning one key on a tick.
  typedef struct packed {
    logic [4:0] flags;    // value written back
    logic       en_set;   // re-enable the key's edge event
    logic       cnt_inc;  // one more key settling
    logic       cnt_dec;  // one key fewer settling
    logic       report;   // key turned stable: send a report
  } key_upd_t;

endpackage
`default_nettype wire

// ===== rtl/mkdb_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module mkdb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mkdb_key_eval.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Key evaluation
// Decides the new flag word of one key during a tick scan.
// ----------------------------------------------------------------------------
module mkdb_key_eval
  import mkdb_pkg::*;
(
  input  wire logic [4:0] flags,
  input  wire logic       level,
  input  wire logic       edge_mode,
  output key_upd_t        upd
);

  logic [4:0] d;

  always_comb begin
    upd = '0;
    d   = flags;
    if (flags[FL_WAIT]) begin
      upd.flags = flags;
    end else begin
      // An unstable key is taken back to unknown and its edge re-armed.
      if (flags[FL_UNSTABLE]) begin
        d          = FLAGS_UNKNOWN;
        upd.en_set = 1'b1;
      end
      upd.flags = d;
      if (d[FL_POLL]) begin
        if (level == !d[FL_PRESSED]) begin
          upd.cnt_inc = 1'b1;
          upd.flags   = FLAGS_UNKNOWN;
        end
      end else if (level && d[FL_NOTPRESSED]) begin
        upd.flags = FLAGS_PRESSED;
      end else if (!level && d[FL_PRESSED]) begin
        upd.flags = FLAGS_NOTPRESSED;
      end else begin
        upd.cnt_dec = 1'b1;
        upd.report  = 1'b1;
        upd.flags   = d | (edge_mode ? FLAGS_WAIT : FLAGS_POLL);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/multi_key_gpio_debouncer_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-key GPIO debouncer core
// Debounces up to 16 key lines with edge-event and polling timer modes.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries commands: tuser 0 is a timer tick that scans all
//   keys in use against the sampled pin levels, tuser 1 is an edge event for
//   the key in key_index. Each input transfer produces one or more output
//   transfers: zero or more key reports (tuser 0) followed by a status item
//   (tuser 1, tlast high) with the next timer action and the edge-enable mask.
//   The scan of a tick is paced by the single read/write port pair of the
//   flag memory, one key read, updated and written back per cycle while no
//   report waits for the output slot. One command is processed at a time;
//   the next input transfer is taken once the status item has been loaded.
//   Results leave through an output register, so a stalled receiver only
//   holds the scan at the next key that needs to report.
//   Reset is synchronous: every key's flags read as unknown (valid bits are
//   cleared, no clearing pass is needed), all edges are enabled and the
//   settling count is loaded with the number of keys in use.
//   Configuration writes are taken at any cycle and belong in idle periods.
// ----------------------------------------------------------------------------
module multi_key_gpio_debouncer_core
  import mkdb_pkg::*;
#(
  parameter int NUM_KEYS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,  // [3:0] key_index, [19:4] pin_levels, rest zero
  input  wire logic        in_tuser,  // command
  // Result stream.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [23:0] out_tdata, // [3:0] report_key, [4] pressed, [6:5] next_timer,
                                      // [22:7] edge_enables, rest zero
  output logic             out_tuser, // kind
  output logic             out_tlast, // last
  // Configuration write port.
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [4:0]  cfg_wdata
);

  localparam int AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam logic [4:0] KEY_LIMIT = (NUM_KEYS < 16) ? 5'(NUM_KEYS) : 5'd16;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_EDGE = 5'b00100,
    S_EREP = 5'b01000,
    S_STAT = 5'b10000
  } state_t;

  // Configuration registers.
  logic       active_high_r, edge_mode_r, debounce_on_r;
  logic [4:0] key_count_r;

  // Control and state.
  state_t              state_r, state_nxt;
  logic [NUM_KEYS-1:0] en_r, en_nxt;
  logic [NUM_KEYS-1:0] vld_r, vld_nxt;
  logic [4:0]          cnt_r, cnt_nxt;
  logic [4:0]          key_r, key_nxt;
  logic                tick_r, tick_nxt;
  logic [1:0]          timer_r, timer_nxt;
  logic                rd_vld_r;
  logic [15:0]         pins_r;
  logic [3:0]          kidx_r;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic [22:0] out_data_r;
  logic        out_kind_r, out_last_r;
  logic        out_load;
  logic [22:0] load_data;
  logic        load_kind, load_last;
  logic        slot_free;

  // Memory ports.
  logic           ram_we, ram_re;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [4:0]     ram_wdata, ram_rdata;
  logic [4:0]     cur_flags;

  // Derived values.
  logic [4:0]  keys_used;
  logic [3:0]  in_key;
  logic [15:0] in_pins;
  logic [6:0]  in_key_ext, key_ext, kidx_ext;
  logic [AW-1:0] in_addr, key_addr, kidx_addr;
  logic [79:0] en_ext;
  logic [15:0] en16;
  logic        scan_level, edge_level;
  logic [1:0]  tick_timer;
  key_upd_t    upd;

  assign keys_used  = (key_count_r > KEY_LIMIT) ? KEY_LIMIT : key_count_r;
  assign in_key     = in_tdata[3:0];
  assign in_pins    = in_tdata[19:4];
  assign in_key_ext = {3'b000, in_key};
  assign key_ext    = {2'b00, key_r};
  assign kidx_ext   = {3'b000, kidx_r};
  assign in_addr    = in_key_ext[AW-1:0];
  assign key_addr   = key_ext[AW-1:0];
  assign kidx_addr  = kidx_ext[AW-1:0];
  assign en_ext     = 80'(en_r);
  assign en16       = en_ext[15:0];
  assign cur_flags  = rd_vld_r ? ram_rdata : FLAGS_UNKNOWN;
  assign scan_level = pins_r[key_r[3:0]] ^ ~active_high_r;
  assign edge_level = pins_r[kidx_r] ^ ~active_high_r;
  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);

  always_comb begin
    if (cnt_r != 5'd0) begin
      tick_timer = TMR_DEBOUNCE;
    end else if (!edge_mode_r) begin
      tick_timer = TMR_POLL;
    end else begin
      tick_timer = TMR_STOP;
    end
  end

  mkdb_ram #(
    .WIDTH (5),
    .DEPTH (NUM_KEYS)
  ) u_flags (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mkdb_key_eval u_eval (
    .flags     (cur_flags),
    .level     (scan_level),
    .edge_mode (edge_mode_r),
    .upd       (upd)
  );

  // Sequencer: accepts a command, then walks the keys or handles one edge.
  always_comb begin
    state_nxt = state_r;
    en_nxt    = en_r;
    vld_nxt   = vld_r;
    cnt_nxt   = cnt_r;
    key_nxt   = key_r;
    tick_nxt  = tick_r;
    timer_nxt = timer_r;
    ram_we    = 1'b0;
    ram_waddr = key_addr;
    ram_wdata = upd.flags;
    ram_re    = 1'b0;
    ram_raddr = key_addr;
    out_load  = 1'b0;
    load_kind = KIND_STATUS;
    load_last = 1'b1;
    load_data = '0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          key_nxt   = 5'd0;
          timer_nxt = TMR_KEEP;
          if (in_tuser == CMD_TICK) begin
            tick_nxt = 1'b1;
            if (keys_used != 5'd0) begin
              ram_re    = 1'b1;
              ram_raddr = '0;
              state_nxt = S_SCAN;
            end else begin
              state_nxt = S_STAT;
            end
          end else begin
            tick_nxt = 1'b0;
            if (edge_mode_r && ({1'b0, in_key} < keys_used) && en_r[in_addr]) begin
              if (debounce_on_r) begin
                ram_re    = 1'b1;
                ram_raddr = in_addr;
                state_nxt = S_EDGE;
              end else begin
                state_nxt = S_EREP;
              end
            end else begin
              state_nxt = S_STAT;
            end
          end
        end
      end

      S_SCAN: begin
        // A report needs the output slot; otherwise the key completes now.
        if (!upd.report || slot_free) begin
          ram_we           = 1'b1;
          vld_nxt[key_addr] = 1'b1;
          if (upd.en_set) begin
            en_nxt[key_addr] = 1'b1;
          end
          if (upd.cnt_inc && cnt_r != 5'd31) begin
            cnt_nxt = cnt_r + 5'd1;
          end
          if (upd.cnt_dec && cnt_r != 5'd0) begin
            cnt_nxt = cnt_r - 5'd1;
          end
          if (upd.report) begin
            out_load  = 1'b1;
            load_kind = KIND_REPORT;
            load_last = 1'b0;
            load_data = {16'h0000, TMR_KEEP, scan_level, key_r[3:0]};
          end
          if (key_r == keys_used - 5'd1) begin
            state_nxt = S_STAT;
          end else begin
            key_nxt   = key_r + 5'd1;
            ram_re    = 1'b1;
            ram_raddr = key_addr + AW'(1);
            state_nxt = S_SCAN;
          end
        end
      end

      S_EDGE: begin
        ram_we             = 1'b1;
        ram_waddr          = kidx_addr;
        vld_nxt[kidx_addr] = 1'b1;
        if (cur_flags[FL_WAIT]) begin
          ram_wdata = FLAGS_UNKNOWN;
          if (cnt_r == 5'd0) begin
            timer_nxt = TMR_DEBOUNCE;
          end
          if (cnt_r != 5'd31) begin
            cnt_nxt = cnt_r + 5'd1;
          end
        end else begin
          ram_wdata         = FLAGS_UNSTABLE;
          en_nxt[kidx_addr] = 1'b0;
        end
        state_nxt = S_STAT;
      end

      S_EREP: begin
        if (slot_free) begin
          out_load  = 1'b1;
          load_kind = KIND_REPORT;
          load_last = 1'b0;
          load_data = {16'h0000, TMR_KEEP, edge_level, kidx_r};
          state_nxt = S_STAT;
        end
      end

      S_STAT: begin
        if (slot_free) begin
          out_load  = 1'b1;
          load_kind = KIND_STATUS;
          load_last = 1'b1;
          load_data = {en16, (tick_r ? tick_timer : timer_r), 1'b0, 4'h0};
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      en_r          <= '1;
      vld_r         <= '0;
      cnt_r         <= KEY_LIMIT;
      key_r         <= 5'd0;
      tick_r        <= 1'b0;
      timer_r       <= TMR_KEEP;
      rd_vld_r      <= 1'b0;
      out_valid_r   <= 1'b0;
      active_high_r <= 1'b0;
      edge_mode_r   <= 1'b1;
      debounce_on_r <= 1'b1;
      key_count_r   <= 5'd16;
    end else begin
      state_r     <= state_nxt;
      en_r        <= en_nxt;
      vld_r       <= vld_nxt;
      cnt_r       <= cnt_nxt;
      key_r       <= key_nxt;
      tick_r      <= tick_nxt;
      timer_r     <= timer_nxt;
      out_valid_r <= out_valid_nxt;
      if (ram_re) begin
        rd_vld_r <= vld_r[ram_raddr];
      end
      if (cfg_we) begin
        case (cfg_addr)
          CFG_ACTIVE_HIGH: active_high_r <= cfg_wdata[0];
          CFG_EDGE_MODE:   edge_mode_r   <= cfg_wdata[0];
          CFG_DEBOUNCE_ON: debounce_on_r <= cfg_wdata[0];
          CFG_KEY_COUNT:   key_count_r   <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      pins_r <= in_pins;
      kidx_r <= in_key;
    end
    if (out_load) begin
      out_data_r <= load_data;
      out_kind_r <= load_kind;
      out_last_r <= load_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_data_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire
